// ===== sv/itmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itmf_pkg
// Shared types and constants of the stimulus packet framer: word layouts,
// header size codes and the burst that one input word can produce.
// ----------------------------------------------------------------------------
package itmf_pkg;

   localparam int unsigned PORT_W      = 5;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned CODE_W      = 3;
   localparam int unsigned PEND_DEPTH  = 3;
   localparam int unsigned GROUP_CNT_W = 2;
   localparam int unsigned BURST_MAX   = 5;
   localparam int unsigned BURST_CNT_W = 3;

   // size codes in the low bits of a software-source header
   localparam logic [CODE_W-1:0] CODE_FULL = 3'd3;
   localparam logic [CODE_W-1:0] CODE_TWO  = 3'd2;
   localparam logic [CODE_W-1:0] CODE_ONE  = 3'd1;

   typedef logic [BYTE_W-1:0] data_type;
   typedef logic [PORT_W-1:0] port_type;

   typedef struct packed {
      port_type port;
      data_type data_byte;
      logic     last_byte;
   } req_word_type;

   typedef struct packed {
      data_type out_byte;
      logic     is_header;
      logic     run_last;
   } rsp_word_type;

   // bytes[0] goes out first; hdr[i] marks bytes[i] as a header
   typedef struct packed {
      logic [BURST_MAX-1:0][BYTE_W-1:0] bytes;
      logic [BURST_MAX-1:0]             hdr;
      logic [BURST_CNT_W-1:0]           len;
   } burst_type;

   function automatic data_type header_byte(input port_type port,
                                            input logic [CODE_W-1:0] code);
      return {port, code};
   endfunction

endpackage

// ===== sv/itmf_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itmf channel interfaces
// Valid/ready channels for request words and framed response words.
// ----------------------------------------------------------------------------
interface itmf_req_if import itmf_pkg::*; ();
   logic     valid;
   logic     ready;
   port_type port;
   data_type data_byte;
   logic     last_byte;

   modport source (output valid, output port, output data_byte, output last_byte,
                   input ready);
   modport sink   (input valid, input port, input data_byte, input last_byte,
                   output ready);
endinterface

interface itmf_rsp_if import itmf_pkg::*; ();
   logic     valid;
   logic     ready;
   data_type out_byte;
   logic     is_header;
   logic     run_last;

   modport source  (output valid, output out_byte, output is_header, output run_last,
                    input ready);
   modport sink    (input valid, input out_byte, input is_header, input run_last,
                    output ready);
   modport monitor (input valid, input ready, input out_byte, input is_header,
                    input run_last);
endinterface

// ===== sv/itm_stimulus_packet_framer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itm_stimulus_packet_framer_unit
// Frames message bytes of one stimulus port into software-source packets.
// ----------------------------------------------------------------------------
// Each request word carries one message byte, its stimulus port and an end of
// message mark. Bytes are gathered in groups of four; the port is latched at
// the first byte of a group. The fourth byte of a group releases a full packet
// (header port<<3|3 and the four bytes). A message end with two bytes open
// releases a two-byte packet (code 2), with three a two-byte and a one-byte
// packet, and a single leftover byte a one-byte packet (code 1), so one word
// produces zero, two, three or five response words. Response words leave at
// one per cycle from an output register while the receiver is ready; run_last
// marks the final one that a request word caused. A word that only stores a
// byte is taken once the burst buffer is free; a word that releases bytes holds
// the burst buffer until they drain, and the next request word is taken in the
// cycle its last byte moves into the output register. In a steady stream of full
// groups the storing words are taken back to back, and the fourth holds the
// request side while its burst drains. The first response word passes through
// the burst buffer and then the output register. No clearing pass after reset.
// ----------------------------------------------------------------------------
module itm_stimulus_packet_framer_unit import itmf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   itmf_req_if.sink   req_chan,
   itmf_rsp_if.source rsp_chan
);

   req_word_type req_word;
   burst_type    burst;
   rsp_word_type rsp_word;
   logic         req_accept;
   logic         load_ready;

   // gather the request payload into one word
   assign req_word.port      = req_chan.port;
   assign req_word.data_byte = req_chan.data_byte;
   assign req_word.last_byte = req_chan.last_byte;

   // accept only when the burst buffer is empty or drains this cycle
   assign req_chan.ready = load_ready;
   assign req_accept     = req_chan.valid && load_ready;

   // group state and packet building
   itmf_framer u_framer (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .word   (req_word),
      .burst  (burst)
   );

   // burst buffer and output register
   itmf_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .load       (req_accept),
      .burst      (burst),
      .load_ready (load_ready),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_word   (rsp_word)
   );

   // drive the response payload
   assign rsp_chan.out_byte  = rsp_word.out_byte;
   assign rsp_chan.is_header = rsp_word.is_header;
   assign rsp_chan.run_last  = rsp_word.run_last;

endmodule

// ===== sv/itmf_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itmf_framer
// Group state of the framer: open group bytes, fill count and latched port.
// Builds the burst of packet bytes that an accepted word releases.
// ----------------------------------------------------------------------------
module itmf_framer import itmf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_word_type word,
   output burst_type    burst
);

   data_type                pend_ff [PEND_DEPTH];
   logic [GROUP_CNT_W-1:0]  count_ff, count_in;
   port_type                port_ff, port_in;

   port_type port_eff;
   data_type b0, b1, b2;

   always_comb begin
      port_eff = (count_ff == '0) ? word.port : port_ff;
      // the new byte stands in for the slot it is about to fill
      b0 = (count_ff == 2'd0) ? word.data_byte : pend_ff[0];
      b1 = (count_ff == 2'd1) ? word.data_byte : pend_ff[1];
      b2 = (count_ff == 2'd2) ? word.data_byte : pend_ff[2];

      burst = '0;
      case (count_ff)
         2'd3: begin
            burst.bytes[0] = header_byte(port_eff, CODE_FULL);
            burst.bytes[1] = pend_ff[0];
            burst.bytes[2] = pend_ff[1];
            burst.bytes[3] = pend_ff[2];
            burst.bytes[4] = word.data_byte;
            burst.hdr      = 5'b00001;
            burst.len      = 3'd5;
         end
         2'd0: begin
            if (word.last_byte) begin
               burst.bytes[0] = header_byte(port_eff, CODE_ONE);
               burst.bytes[1] = b0;
               burst.hdr      = 5'b00001;
               burst.len      = 3'd2;
            end
         end
         2'd1: begin
            if (word.last_byte) begin
               burst.bytes[0] = header_byte(port_eff, CODE_TWO);
               burst.bytes[1] = b0;
               burst.bytes[2] = b1;
               burst.hdr      = 5'b00001;
               burst.len      = 3'd3;
            end
         end
         default: begin
            if (word.last_byte) begin
               burst.bytes[0] = header_byte(port_eff, CODE_TWO);
               burst.bytes[1] = b0;
               burst.bytes[2] = b1;
               burst.bytes[3] = header_byte(port_eff, CODE_ONE);
               burst.bytes[4] = b2;
               burst.hdr      = 5'b01001;
               burst.len      = 3'd5;
            end
         end
      endcase

      count_in = count_ff;
      port_in  = port_ff;
      if (accept) begin
         port_in  = port_eff;
         count_in = (count_ff == 2'd3 || word.last_byte) ? '0 : count_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         port_ff  <= '0;
      end else begin
         count_ff <= count_in;
         port_ff  <= port_in;
      end
   end

   // open group bytes: no reset, only slots of the current group are read
   always_ff @(posedge clock) begin
      if (accept && count_ff != 2'd3) begin
         pend_ff[count_ff] <= word.data_byte;
      end
   end

endmodule

// ===== sv/itmf_serializer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itmf_serializer
// Burst buffer and output register: shifts out a byte a cycle unless stalled.
// ----------------------------------------------------------------------------
module itmf_serializer import itmf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  burst_type    burst,
   output logic         load_ready,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);

   burst_type    buf_ff, buf_in;
   logic         valid_ff, valid_in;
   rsp_word_type word_ff;
   logic         move;

   assign move       = (buf_ff.len != '0) && (!valid_ff || rsp_ready);
   assign load_ready = (buf_ff.len == '0) || (buf_ff.len == 3'd1 && move);

   always_comb begin
      buf_in = buf_ff;
      if (load) begin
         buf_in = burst;
      end else if (move) begin
         for (int i = 0; i < BURST_MAX - 1; i++) begin
            buf_in.bytes[i] = buf_ff.bytes[i+1];
         end
         buf_in.hdr = buf_ff.hdr >> 1;
         buf_in.len = buf_ff.len - 3'd1;
      end

      if (move) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // payload bytes carry no reset; only the length and valid do
   always_ff @(posedge clock) begin
      buf_ff.bytes <= buf_in.bytes;
      buf_ff.hdr   <= buf_in.hdr;
      if (move) begin
         word_ff.out_byte  <= buf_ff.bytes[0];
         word_ff.is_header <= buf_ff.hdr[0];
         word_ff.run_last  <= (buf_ff.len == 3'd1);
      end
      if (reset) begin
         buf_ff.len <= '0;
         valid_ff   <= 1'b0;
      end else begin
         buf_ff.len <= buf_in.len;
         valid_ff   <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

// ===== sv/itmf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itmf_checker
// Port-level checks on the framed response stream of the framer.
// ----------------------------------------------------------------------------
module itmf_checker import itmf_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input data_type rsp_out_byte,
   input logic     rsp_is_header,
   input logic     rsp_run_last
);

   // hold a stalled word until taken
   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_out_byte) && $stable(rsp_is_header) &&
         $stable(rsp_run_last))
      else $error("stalled response word changed");

   // a header carries a size code of one, two or four bytes
   a_header_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_header |->
         (rsp_out_byte[2:0] == CODE_ONE || rsp_out_byte[2:0] == CODE_TWO ||
          rsp_out_byte[2:0] == CODE_FULL))
      else $error("header with bad size code");

   // a burst never ends on a header
   a_header_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_header && rsp_run_last))
      else $error("burst ends on a header");

   // nothing is shown right after reset
   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind itm_stimulus_packet_framer_unit itmf_checker u_itmf_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_out_byte  (rsp_chan.out_byte),
   .rsp_is_header (rsp_chan.is_header),
   .rsp_run_last  (rsp_chan.run_last)
);
